### rtl/c8bf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8bf_pkg
// Shared types, constants and the CRC-8 byte update for the block framer.
// ----------------------------------------------------------------------------
package c8bf_pkg;

   localparam int BlockLen  = 8;
   localparam int CountW    = 6;
   localparam int DataW     = 8;
   localparam int KindW     = 2;
   localparam int CsrIdxW   = 2;
   localparam int FifoDepth = 2;
   localparam int FifoAw    = 1;

   localparam logic [DataW-1:0] StartByteRst = 8'h0F;
   localparam logic [DataW-1:0] CrcInitRst   = 8'hFF;
   localparam logic [DataW-1:0] CrcPolyRst   = 8'h07;

   typedef enum logic [KindW-1:0] {
      KIND_START   = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_CRC     = 2'd2
   } kind_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_START_BYTE = 2'd0,
      CSR_CRC_INIT   = 2'd1,
      CSR_CRC_POLY   = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_BEGIN,
      ST_PAYLOAD,
      ST_CRC,
      ST_TAIL
   } back_state_type;

   typedef struct packed {
      logic             first;
      logic             close;
      logic [DataW-1:0] data;
      logic [DataW-1:0] crc;
   } job_type;

   function automatic logic [DataW-1:0] crc8_update(
      input logic [DataW-1:0] crc_reg,
      input logic [DataW-1:0] data,
      input logic [DataW-1:0] poly
   );
      logic [DataW-1:0] r;
      r = crc_reg ^ data;
      for (int i = 0; i < DataW; i++) begin
         if (r[DataW-1]) begin
            r = {r[DataW-2:0], 1'b0} ^ poly;
         end else begin
            r = {r[DataW-2:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/crc8_block_framer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc8_block_framer
// Byte stream framer: start marker, payload pass-through, per-block CRC-8.
// ----------------------------------------------------------------------------
// A data word inside a block yields one output word; the word that closes a
// block of BLOCK_LEN words yields three (payload, CRC, start marker) and the
// very first word after reset one more for the leading start marker. The
// single output register issues one word per cycle while rsp_stall is low.
// A two-entry job queue lets input keep flowing while the output side is
// stalled, until the queue is full. The config port is always ready; writes
// to index 3 are dropped.
// ----------------------------------------------------------------------------
module crc8_block_framer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [c8bf_pkg::DataW-1:0]    req_data_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [c8bf_pkg::DataW-1:0]         rsp_out_byte,
   output logic [c8bf_pkg::KindW-1:0]         rsp_byte_kind,
   output logic                               rsp_last,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [c8bf_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [c8bf_pkg::DataW-1:0]    csr_data
);

   logic [c8bf_pkg::DataW-1:0] start_byte_ff, start_byte_in;
   logic [c8bf_pkg::DataW-1:0] crc_init_ff, crc_init_in;
   logic [c8bf_pkg::DataW-1:0] crc_poly_ff, crc_poly_in;
   logic                       fifo_full;
   logic                       push;
   c8bf_pkg::job_type          push_job;
   logic                       pop;
   logic                       head_valid;
   c8bf_pkg::job_type          head;

   assign csr_ready = 1'b1;

   always_comb begin
      start_byte_in = start_byte_ff;
      crc_init_in   = crc_init_ff;
      crc_poly_in   = crc_poly_ff;
      if (csr_valid) begin
         unique case (csr_index)
            c8bf_pkg::CSR_START_BYTE: start_byte_in = csr_data;
            c8bf_pkg::CSR_CRC_INIT:   crc_init_in   = csr_data;
            c8bf_pkg::CSR_CRC_POLY:   crc_poly_in   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= c8bf_pkg::StartByteRst;
         crc_init_ff   <= c8bf_pkg::CrcInitRst;
         crc_poly_ff   <= c8bf_pkg::CrcPolyRst;
      end else begin
         start_byte_ff <= start_byte_in;
         crc_init_ff   <= crc_init_in;
         crc_poly_ff   <= crc_poly_in;
      end
   end

   c8bf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .crc_init      (crc_init_ff),
      .crc_poly      (crc_poly_ff),
      .fifo_full     (fifo_full),
      .push          (push),
      .push_job      (push_job)
   );

   c8bf_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (fifo_full),
      .head_valid (head_valid),
      .head       (head)
   );

   c8bf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head          (head),
      .pop           (pop),
      .start_byte    (start_byte_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_byte_kind (rsp_byte_kind),
      .rsp_last      (rsp_last)
   );

endmodule
`default_nettype wire

### rtl/c8bf_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8bf_front
// Takes data words, runs the block CRC and count, and queues a job per word.
// ----------------------------------------------------------------------------
module c8bf_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [c8bf_pkg::DataW-1:0]  req_data_byte,
   input  wire logic [c8bf_pkg::DataW-1:0]  crc_init,
   input  wire logic [c8bf_pkg::DataW-1:0]  crc_poly,
   input  wire logic                        fifo_full,
   output logic                             push,
   output c8bf_pkg::job_type                push_job
);

   logic                          started_ff, started_in;
   logic [c8bf_pkg::CountW-1:0]   count_ff, count_in;
   logic [c8bf_pkg::DataW-1:0]    acc_ff, acc_in;
   logic [c8bf_pkg::DataW-1:0]    base;
   logic [c8bf_pkg::DataW-1:0]    crc_new;
   logic [c8bf_pkg::CountW-1:0]   count_inc;
   logic                          close;

   assign req_stall = fifo_full;
   assign push      = req_valid && !fifo_full;

   assign base      = (count_ff == '0) ? crc_init : acc_ff;
   assign crc_new   = c8bf_pkg::crc8_update(base, req_data_byte, crc_poly);
   assign count_inc = count_ff + c8bf_pkg::CountW'(1);
   assign close     = (count_inc >= c8bf_pkg::CountW'(c8bf_pkg::BlockLen)) ||
                      (count_inc == '0);

   always_comb begin
      push_job.first = !started_ff;
      push_job.close = close;
      push_job.data  = req_data_byte;
      push_job.crc   = crc_new;
      started_in     = started_ff;
      count_in       = count_ff;
      acc_in         = acc_ff;
      if (push) begin
         started_in = 1'b1;
         count_in   = close ? '0 : count_inc;
         acc_in     = crc_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         started_ff <= started_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

endmodule
`default_nettype wire

### rtl/c8bf_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8bf_fifo
// Short job queue between the front and back halves.
// ----------------------------------------------------------------------------
module c8bf_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire c8bf_pkg::job_type  push_job,
   input  wire logic               pop,
   output logic                    full,
   output logic                    head_valid,
   output c8bf_pkg::job_type       head
);

   c8bf_pkg::job_type              mem_ff [c8bf_pkg::FifoDepth];
   logic [c8bf_pkg::FifoAw-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [c8bf_pkg::FifoAw-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [c8bf_pkg::FifoAw:0]      cnt_ff, cnt_in;

   localparam logic [c8bf_pkg::FifoAw-1:0] PtrLast =
      c8bf_pkg::FifoAw'(c8bf_pkg::FifoDepth - 1);
   localparam logic [c8bf_pkg::FifoAw:0] CntFull =
      (c8bf_pkg::FifoAw + 1)'(c8bf_pkg::FifoDepth);
   localparam logic [c8bf_pkg::FifoAw:0] CntOne =
      (c8bf_pkg::FifoAw + 1)'(1);

   assign full       = (cnt_ff == CntFull);
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CntOne;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CntOne;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntFull)
      else $error("fifo count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into full fifo");

endmodule
`default_nettype wire

### rtl/c8bf_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8bf_back
// Expands each queued job into its payload word on the output, with start and CRC words where the job calls for them.
// ----------------------------------------------------------------------------
module c8bf_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        head_valid,
   input  wire c8bf_pkg::job_type           head,
   output logic                             pop,
   input  wire logic [c8bf_pkg::DataW-1:0]  start_byte,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [c8bf_pkg::DataW-1:0]       rsp_out_byte,
   output logic [c8bf_pkg::KindW-1:0]       rsp_byte_kind,
   output logic                             rsp_last
);

   c8bf_pkg::back_state_type        state_ff, state_in;
   logic                            valid_ff, valid_in;
   logic [c8bf_pkg::DataW-1:0]      byte_ff;
   c8bf_pkg::kind_type              kind_ff;
   logic                            last_ff;
   logic [c8bf_pkg::DataW-1:0]      w_byte;
   c8bf_pkg::kind_type              w_kind;
   logic                            w_last;
   logic                            load;

   assign load = head_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      w_byte   = head.data;
      w_kind   = c8bf_pkg::KIND_PAYLOAD;
      w_last   = 1'b0;
      unique case (state_ff)
         c8bf_pkg::ST_BEGIN: begin
            if (head.first) begin
               w_byte   = start_byte;
               w_kind   = c8bf_pkg::KIND_START;
               state_in = c8bf_pkg::ST_PAYLOAD;
            end else begin
               w_last   = !head.close;
               state_in = head.close ? c8bf_pkg::ST_CRC : c8bf_pkg::ST_BEGIN;
            end
         end
         c8bf_pkg::ST_PAYLOAD: begin
            w_last   = !head.close;
            state_in = head.close ? c8bf_pkg::ST_CRC : c8bf_pkg::ST_BEGIN;
         end
         c8bf_pkg::ST_CRC: begin
            w_byte   = head.crc;
            w_kind   = c8bf_pkg::KIND_CRC;
            state_in = c8bf_pkg::ST_TAIL;
         end
         c8bf_pkg::ST_TAIL: begin
            w_byte   = start_byte;
            w_kind   = c8bf_pkg::KIND_START;
            w_last   = 1'b1;
            state_in = c8bf_pkg::ST_BEGIN;
         end
         default: begin
            state_in = c8bf_pkg::ST_BEGIN;
         end
      endcase
      if (!load) begin
         state_in = state_ff;
      end
      pop = load && w_last;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= c8bf_pkg::ST_BEGIN;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= w_byte;
         kind_ff <= w_kind;
         last_ff <= w_last;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_byte_kind = kind_ff;
   assign rsp_last      = last_ff;

   a_crc_needs_close: assert property (@(posedge clock) disable iff (reset)
      (state_ff == c8bf_pkg::ST_CRC || state_ff == c8bf_pkg::ST_TAIL)
         |-> (head_valid && head.close))
      else $error("crc phase without a closing job");

   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (valid_ff && last_ff))
      else $error("job retired without a last word");

endmodule
`default_nettype wire
